// ----- hdl/gpioc_pkg.sv -----
// Shared package for the GPIO controller with edge and level interrupts.
// Holds field widths, mode and register select codes, and the per-pin lane word.
// No dependencies; every other file in hdl/ imports it.
package gpioc_pkg;

    localparam int MAX_PINS_DEF = 16;
    localparam int MODE_W       = 2;
    localparam int SEL_W        = 4;
    localparam int DATA_W       = 32;
    localparam int PIN_W        = 16;
    localparam int CNT_W        = 5;
    localparam int APB_ADDR_W   = 3;

    localparam logic [CNT_W-1:0] PINS_RESET = 5'd16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

    // Register selects
    localparam logic [SEL_W-1:0] SEL_OUT       = 4'd0;
    localparam logic [SEL_W-1:0] SEL_OE        = 4'd1;
    localparam logic [SEL_W-1:0] SEL_PINS      = 4'd2;
    localparam logic [SEL_W-1:0] SEL_PULLUP    = 4'd3;
    localparam logic [SEL_W-1:0] SEL_PULLDOWN  = 4'd4;
    localparam logic [SEL_W-1:0] SEL_EDGE_EN   = 4'd5;
    localparam logic [SEL_W-1:0] SEL_LEVEL_EN  = 4'd6;
    localparam logic [SEL_W-1:0] SEL_EDGE_STS  = 4'd7;
    localparam logic [SEL_W-1:0] SEL_LEVEL_STS = 4'd8;

    // What one pin lane found on a sample tick
    typedef struct packed {
        logic rise;
        logic fall;
        logic high;
        logic low;
    } lane_flags_t;

endpackage

// ----- hdl/gpioc_lane.sv -----
// One pin lane: edge and level detection for a single pin on a sample tick.
// Depends on gpioc_pkg for the lane word type.
module gpioc_lane (
    input  logic                  level,
    input  logic                  last,
    input  logic                  in_use,
    output gpioc_pkg::lane_flags_t flags
);
    import gpioc_pkg::*;

    // level and last arrive already masked to the pins in use
    always_comb
    begin
        flags.rise = level & ~last;
        flags.fall = ~level & last;
        flags.high = level;
        flags.low  = ~level & in_use;
    end

endmodule

// ----- hdl/gpioc_merge.sv -----
// Merge stage: packs the lane flags into the two-half interrupt layout.
// Lower half takes rising / level-high at bit i, upper half falling / level-low at i+n.
// Depends on gpioc_pkg.
module gpioc_merge #(
    parameter int MAX_PINS = gpioc_pkg::MAX_PINS_DEF
) (
    input  gpioc_pkg::lane_flags_t         lane_flags [MAX_PINS],
    input  logic [gpioc_pkg::CNT_W-1:0]    pin_cnt,
    output logic [2*MAX_PINS-1:0]          edge_set,
    output logic [2*MAX_PINS-1:0]          level_set
);
    import gpioc_pkg::*;

    logic [MAX_PINS-1:0] rise_vec;
    logic [MAX_PINS-1:0] fall_vec;
    logic [MAX_PINS-1:0] high_vec;
    logic [MAX_PINS-1:0] low_vec;

    always_comb
    begin
        for (int i = 0; i < MAX_PINS; i++)
        begin
            rise_vec[i] = lane_flags[i].rise;
            fall_vec[i] = lane_flags[i].fall;
            high_vec[i] = lane_flags[i].high;
            low_vec[i]  = lane_flags[i].low;
        end
    end

    // Upper half sits at the pin count, so shift it up by n
    assign edge_set  = {{MAX_PINS{1'b0}}, rise_vec}
                     | ({{MAX_PINS{1'b0}}, fall_vec} << pin_cnt);
    assign level_set = {{MAX_PINS{1'b0}}, high_vec}
                     | ({{MAX_PINS{1'b0}}, low_vec} << pin_cnt);

endmodule

// ----- hdl/gpio_controller_edge_level_irq.sv -----
// GPIO controller with edge and level interrupts: register file, pin lanes, result word.
// A request word is accepted and its result word appears on the next cycle.
// Throughput: one request word per cycle; state updates in the accept cycle, so the
// next word may follow at once. A stalled result holds and stalls the request side.
// Reset (rst_n, async, active low) clears the controller state registers, sets the pin count
// to 16, and clears the result valid flag. Depends on gpioc_pkg, gpioc_lane, gpioc_merge.
module gpio_controller_edge_level_irq #(
    parameter int MAX_PINS = gpioc_pkg::MAX_PINS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gpioc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gpioc_pkg::DATA_W-1:0]       pwdata,
    output logic [gpioc_pkg::DATA_W-1:0]       prdata,
    output logic                               pready,
    // request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [gpioc_pkg::MODE_W-1:0]       mode,
    input  logic [gpioc_pkg::SEL_W-1:0]        reg_select,
    input  logic [gpioc_pkg::DATA_W-1:0]       write_data,
    input  logic [gpioc_pkg::PIN_W-1:0]        pin_levels,
    // result channel
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [gpioc_pkg::DATA_W-1:0]       read_data,
    output logic                               access_error,
    output logic                               irq_line,
    output logic [gpioc_pkg::PIN_W-1:0]        pad_out,
    output logic [gpioc_pkg::PIN_W-1:0]        pad_oe,
    output logic [gpioc_pkg::PIN_W-1:0]        pad_pullup,
    output logic [gpioc_pkg::PIN_W-1:0]        pad_pulldown
);
    import gpioc_pkg::*;

    localparam int IRQ_W  = 2 * MAX_PINS;
    localparam int CNT2_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PINS);

    // ------------------------------------------------------------------
    // Configuration register: pin count
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] pins_in_use_reg;
    logic             cfg_hit;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == '0);
    assign cfg_write = psel & penable & pwrite & pready & cfg_hit;
    assign prdata    = cfg_hit ? DATA_W'(pins_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pins_in_use_reg <= PINS_RESET;
        else if (cfg_write)
            pins_in_use_reg <= pwdata[CNT_W-1:0];
    end

    // Clamp the pin count to 1..MAX_PINS, then build the pin and interrupt masks
    logic [CNT_W-1:0]    pin_cnt;
    logic [MAX_PINS-1:0] pin_mask;
    logic [IRQ_W-1:0]    irq_mask;

    assign pin_cnt = (pins_in_use_reg == '0)     ? CNT_W'(1) :
                     (pins_in_use_reg > MAX_CNT) ? MAX_CNT   : pins_in_use_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_PINS; i++)
            pin_mask[i] = (CNT_W'(i) < pin_cnt);
        for (int j = 0; j < IRQ_W; j++)
            irq_mask[j] = (CNT2_W'(j) < {pin_cnt, 1'b0});
    end

    // ------------------------------------------------------------------
    // Driver-visible registers
    // ------------------------------------------------------------------
    logic [MAX_PINS-1:0] out_value_reg,  out_value_next;
    logic [MAX_PINS-1:0] out_enable_reg, out_enable_next;
    logic [MAX_PINS-1:0] pull_up_reg,    pull_up_next;
    logic [MAX_PINS-1:0] pull_down_reg,  pull_down_next;
    logic [IRQ_W-1:0]    edge_en_reg,    edge_en_next;
    logic [IRQ_W-1:0]    level_en_reg,   level_en_next;
    logic [IRQ_W-1:0]    edge_sts_reg,   edge_sts_next;
    logic [IRQ_W-1:0]    level_sts_reg,  level_sts_next;
    logic [MAX_PINS-1:0] last_pin_reg,   last_pin_next;

    logic req_fire;
    assign req_fire = req_valid & ~req_stall;

    // ------------------------------------------------------------------
    // Pin lanes and merge stage
    // ------------------------------------------------------------------
    lane_flags_t        lane_flags [MAX_PINS];
    logic [IRQ_W-1:0]   edge_set;
    logic [IRQ_W-1:0]   level_set;

    for (genvar g = 0; g < MAX_PINS; g++)
    begin : g_lane
        gpioc_lane u_lane (
            .level  (pin_levels[g] & pin_mask[g]),
            .last   (last_pin_reg[g] & pin_mask[g]),
            .in_use (pin_mask[g]),
            .flags  (lane_flags[g])
        );
    end

    gpioc_merge #(
        .MAX_PINS (MAX_PINS)
    ) u_merge (
        .lane_flags (lane_flags),
        .pin_cnt    (pin_cnt),
        .edge_set   (edge_set),
        .level_set  (level_set)
    );

    // ------------------------------------------------------------------
    // Next state and result word for the word on the request channel
    // ------------------------------------------------------------------
    logic [MAX_PINS-1:0] wd_pin;
    logic [IRQ_W-1:0]    wd_irq;
    logic [DATA_W-1:0]   rd_next;
    logic                err_next;
    logic                irq_next;

    assign wd_pin = write_data[MAX_PINS-1:0];
    assign wd_irq = write_data[IRQ_W-1:0];

    always_comb
    begin
        out_value_next  = out_value_reg;
        out_enable_next = out_enable_reg;
        pull_up_next    = pull_up_reg;
        pull_down_next  = pull_down_reg;
        edge_en_next    = edge_en_reg;
        level_en_next   = level_en_reg;
        edge_sts_next   = edge_sts_reg;
        level_sts_next  = level_sts_reg;
        last_pin_next   = last_pin_reg;
        rd_next         = '0;
        err_next        = 1'b0;

        case (mode)
            MODE_READ:
            begin
                case (reg_select)
                    SEL_OUT:       rd_next = DATA_W'(out_value_reg & pin_mask);
                    SEL_OE:        rd_next = DATA_W'(out_enable_reg & pin_mask);
                    SEL_PINS:      rd_next = DATA_W'(last_pin_reg & pin_mask);
                    SEL_PULLUP:    rd_next = DATA_W'(pull_up_reg & pin_mask);
                    SEL_PULLDOWN:  rd_next = DATA_W'(pull_down_reg & pin_mask);
                    SEL_EDGE_EN:   rd_next = DATA_W'(edge_en_reg & irq_mask);
                    SEL_LEVEL_EN:  rd_next = DATA_W'(level_en_reg & irq_mask);
                    SEL_EDGE_STS:  rd_next = DATA_W'(edge_sts_reg & irq_mask);
                    SEL_LEVEL_STS: rd_next = DATA_W'(level_sts_reg & irq_mask);
                    default:       rd_next = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (reg_select)
                    SEL_OUT:       out_value_next  = wd_pin & pin_mask;
                    SEL_OE:        out_enable_next = wd_pin & pin_mask;
                    SEL_PINS:      err_next        = 1'b1;
                    SEL_PULLUP:    pull_up_next    = wd_pin & pin_mask;
                    SEL_PULLDOWN:  pull_down_next  = wd_pin & pin_mask;
                    SEL_EDGE_EN:   edge_en_next    = wd_irq & irq_mask;
                    SEL_LEVEL_EN:  level_en_next   = wd_irq & irq_mask;
                    // write-one-to-clear
                    SEL_EDGE_STS:  edge_sts_next   = edge_sts_reg & ~wd_irq & irq_mask;
                    SEL_LEVEL_STS: level_sts_next  = level_sts_reg & ~wd_irq & irq_mask;
                    default:       err_next        = 1'b0;
                endcase
            end
            MODE_TICK:
            begin
                // status sets regardless of enables; level bits re-set every tick
                edge_sts_next  = (edge_sts_reg | edge_set) & irq_mask;
                level_sts_next = (level_sts_reg | level_set) & irq_mask;
                last_pin_next  = pin_levels[MAX_PINS-1:0] & pin_mask;
            end
            default:
            begin
                // idle word: no state change, empty read data
                rd_next = '0;
            end
        endcase

        irq_next = |(((edge_sts_next & edge_en_next) |
                      (level_sts_next & level_en_next)) & irq_mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_value_reg  <= '0;
            out_enable_reg <= '0;
            pull_up_reg    <= '0;
            pull_down_reg  <= '0;
            edge_en_reg    <= '0;
            level_en_reg   <= '0;
            edge_sts_reg   <= '0;
            level_sts_reg  <= '0;
            last_pin_reg   <= '0;
        end
        else if (req_fire)
        begin
            out_value_reg  <= out_value_next;
            out_enable_reg <= out_enable_next;
            pull_up_reg    <= pull_up_next;
            pull_down_reg  <= pull_down_next;
            edge_en_reg    <= edge_en_next;
            level_en_reg   <= level_en_next;
            edge_sts_reg   <= edge_sts_next;
            level_sts_reg  <= level_sts_next;
            last_pin_reg   <= last_pin_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: holds one word; the request side stalls only while
    // a held word is itself stalled
    // ------------------------------------------------------------------
    logic                rsp_valid_reg;
    logic [DATA_W-1:0]   read_data_reg;
    logic                access_error_reg;
    logic                irq_line_reg;
    logic [PIN_W-1:0]    pad_out_reg;
    logic [PIN_W-1:0]    pad_oe_reg;
    logic [PIN_W-1:0]    pad_pullup_reg;
    logic [PIN_W-1:0]    pad_pulldown_reg;

    assign req_stall = rsp_valid_reg & rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (req_fire)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            read_data_reg    <= rd_next;
            access_error_reg <= err_next;
            irq_line_reg     <= irq_next;
            pad_out_reg      <= PIN_W'(out_value_next & pin_mask);
            pad_oe_reg       <= PIN_W'(out_enable_next & pin_mask);
            pad_pullup_reg   <= PIN_W'(pull_up_next & pin_mask);
            pad_pulldown_reg <= PIN_W'(pull_down_next & pin_mask);
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = read_data_reg;
    assign access_error = access_error_reg;
    assign irq_line     = irq_line_reg;
    assign pad_out      = pad_out_reg;
    assign pad_oe       = pad_oe_reg;
    assign pad_pullup   = pad_pullup_reg;
    assign pad_pulldown = pad_pulldown_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty result register never stalls the request side
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> !req_stall)
        else $error("request stalled with empty result register");

    // Access error flags exactly a write to the pin register
    a_err_only_pin_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && rst_n) |=>
            (access_error == ($past(mode) == MODE_WRITE && $past(reg_select) == SEL_PINS)))
        else $error("access error does not match the accepted word");

    // Read data is zero on anything but a read
    a_rd_zero_non_read: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && rst_n && mode != MODE_READ) |=> (read_data == '0))
        else $error("read data nonzero on a non-read word");

    // A sample tick stores the masked pin levels
    a_tick_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && rst_n && mode == MODE_TICK) |=>
            (last_pin_reg == $past(pin_levels[MAX_PINS-1:0] & pin_mask)))
        else $error("pin sample not captured on tick");

    // Status registers change only on an accepted word
    a_sts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!req_fire && rst_n) |=> ($stable(edge_sts_reg) && $stable(level_sts_reg)))
        else $error("interrupt status changed without an accepted word");

endmodule

// ----- tb/tb_gpio_controller_edge_level_irq.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gpio_controller_edge_level_irq: register access, pin sample
// ticks, edge and level interrupt status, and the pin count setting on the APB-style port.
// Depends on gpioc_pkg and the RTL under hdl/.
module tb_gpio_controller_edge_level_irq;

    import gpioc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TB_MAX_PINS = MAX_PINS_DEF;
    localparam int REPORT_MAX  = 10;

    // Codes the package leaves out
    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd3;
    localparam logic [SEL_W-1:0]  SEL_UNUSED_LO  = 4'd9;
    localparam logic [SEL_W-1:0]  SEL_UNUSED_HI  = 4'd15;

    // Configuration register map: one register, the pin count, at index 0
    localparam int REG_PINS_IN_USE = 0;
    localparam logic [APB_ADDR_W-1:0] ADDR_PINS_IN_USE = APB_ADDR_W'(4 * REG_PINS_IN_USE);

    // One result word as the block presents it
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              access_error;
        logic              irq_line;
        logic [PIN_W-1:0]  pad_out;
        logic [PIN_W-1:0]  pad_oe;
        logic [PIN_W-1:0]  pad_pullup;
        logic [PIN_W-1:0]  pad_pulldown;
    } gpio_result_t;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0]     pwdata       = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  req_valid    = 1'b0;
    logic                  req_stall;
    logic [MODE_W-1:0]     mode         = MODE_IDLE;
    logic [SEL_W-1:0]      reg_select   = '0;
    logic [DATA_W-1:0]     write_data   = '0;
    logic [PIN_W-1:0]      pin_levels   = '0;
    logic                  rsp_valid;
    logic                  rsp_stall    = 1'b0;
    logic [DATA_W-1:0]     read_data;
    logic                  access_error;
    logic                  irq_line;
    logic [PIN_W-1:0]      pad_out;
    logic [PIN_W-1:0]      pad_oe;
    logic [PIN_W-1:0]      pad_pullup;
    logic [PIN_W-1:0]      pad_pulldown;

    gpio_controller_edge_level_irq u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .mode         (mode),
        .reg_select   (reg_select),
        .write_data   (write_data),
        .pin_levels   (pin_levels),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .read_data    (read_data),
        .access_error (access_error),
        .irq_line     (irq_line),
        .pad_out      (pad_out),
        .pad_oe       (pad_oe),
        .pad_pullup   (pad_pullup),
        .pad_pulldown (pad_pulldown)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the controller state, updated on each accepted word
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  shadow_pin_cfg = PINS_RESET;
    logic [PIN_W-1:0]  shadow_out       = '0;
    logic [PIN_W-1:0]  shadow_oe        = '0;
    logic [PIN_W-1:0]  shadow_pullup    = '0;
    logic [PIN_W-1:0]  shadow_pulldown  = '0;
    logic [DATA_W-1:0] shadow_edge_en   = '0;
    logic [DATA_W-1:0] shadow_level_en  = '0;
    logic [DATA_W-1:0] shadow_edge_sts  = '0;
    logic [DATA_W-1:0] shadow_level_sts = '0;
    logic [PIN_W-1:0]  shadow_last_pins = '0;

    gpio_result_t predicted_words[$];

    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          burst_mode     = 1'b0;   // sender never idles while set
    bit          rsp_stall_on   = 1'b1;   // receiver may stall while set
    int          stall_hold     = 0;
    logic [PIN_W-1:0] cur_levels = '0;

    // Apply one request word to the shadow state and queue the result it must produce.
    function automatic void compute_result_word(input logic [MODE_W-1:0] md,
                                                input logic [SEL_W-1:0]  sel,
                                                input logic [DATA_W-1:0] wd,
                                                input logic [PIN_W-1:0]  lv);
        int                n;
        logic [DATA_W-1:0] pin_mask;
        logic [DATA_W-1:0] irq_mask;
        logic [DATA_W-1:0] now_pins;
        logic [DATA_W-1:0] prev_pins;
        logic [DATA_W-1:0] rise_bits;
        logic [DATA_W-1:0] fall_bits;
        logic [DATA_W-1:0] low_bits;
        gpio_result_t      word;

        // Clamp the pin count to 1..MAX_PINS
        if (shadow_pin_cfg == 0)
            n = 1;
        else if (shadow_pin_cfg > TB_MAX_PINS)
            n = TB_MAX_PINS;
        else
            n = int'(shadow_pin_cfg);
        pin_mask = (32'd1 << n) - 32'd1;
        irq_mask = (2 * n >= 32) ? '1 : ((32'd1 << (2 * n)) - 32'd1);

        word = '0;
        case (md)
            MODE_READ: begin
                case (sel)
                    SEL_OUT:       word.read_data = {16'd0, shadow_out} & pin_mask;
                    SEL_OE:        word.read_data = {16'd0, shadow_oe} & pin_mask;
                    SEL_PINS:      word.read_data = {16'd0, shadow_last_pins} & pin_mask;
                    SEL_PULLUP:    word.read_data = {16'd0, shadow_pullup} & pin_mask;
                    SEL_PULLDOWN:  word.read_data = {16'd0, shadow_pulldown} & pin_mask;
                    SEL_EDGE_EN:   word.read_data = shadow_edge_en & irq_mask;
                    SEL_LEVEL_EN:  word.read_data = shadow_level_en & irq_mask;
                    SEL_EDGE_STS:  word.read_data = shadow_edge_sts & irq_mask;
                    SEL_LEVEL_STS: word.read_data = shadow_level_sts & irq_mask;
                    default:       word.read_data = '0;
                endcase
            end
            MODE_WRITE: begin
                case (sel)
                    SEL_OUT:       shadow_out       = PIN_W'(wd & pin_mask);
                    SEL_OE:        shadow_oe        = PIN_W'(wd & pin_mask);
                    SEL_PINS:      word.access_error = 1'b1;
                    SEL_PULLUP:    shadow_pullup    = PIN_W'(wd & pin_mask);
                    SEL_PULLDOWN:  shadow_pulldown  = PIN_W'(wd & pin_mask);
                    SEL_EDGE_EN:   shadow_edge_en   = wd & irq_mask;
                    SEL_LEVEL_EN:  shadow_level_en  = wd & irq_mask;
                    SEL_EDGE_STS:  shadow_edge_sts  = shadow_edge_sts & ~wd & irq_mask;
                    SEL_LEVEL_STS: shadow_level_sts = shadow_level_sts & ~wd & irq_mask;
                    default:       ;
                endcase
            end
            MODE_TICK: begin
                now_pins  = {16'd0, lv} & pin_mask;
                prev_pins = {16'd0, shadow_last_pins} & pin_mask;
                rise_bits = now_pins & ~prev_pins;
                fall_bits = ~now_pins & prev_pins & pin_mask;
                low_bits  = ~now_pins & pin_mask;
                shadow_edge_sts  = (shadow_edge_sts | rise_bits | (fall_bits << n)) & irq_mask;
                shadow_level_sts = (shadow_level_sts | now_pins | (low_bits << n)) & irq_mask;
                shadow_last_pins = PIN_W'(now_pins);
            end
            default: ;
        endcase

        word.irq_line = (((shadow_edge_sts & shadow_edge_en) |
                          (shadow_level_sts & shadow_level_en)) & irq_mask) != '0;
        word.pad_out      = shadow_out & PIN_W'(pin_mask);
        word.pad_oe       = shadow_oe & PIN_W'(pin_mask);
        word.pad_pullup   = shadow_pullup & PIN_W'(pin_mask);
        word.pad_pulldown = shadow_pulldown & PIN_W'(pin_mask);
        predicted_words.push_back(word);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("[%0t] %s mismatch: expected 0x%08h, got 0x%08h",
                         $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk) begin
        gpio_result_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("[%0t] result word with no prediction pending", $realtime);
            end else begin
                want = predicted_words.pop_front();
                check_field("read_data",    want.read_data,    read_data);
                check_field("access_error", DATA_W'(want.access_error),
                            DATA_W'(access_error));
                check_field("irq_line",     DATA_W'(want.irq_line), DATA_W'(irq_line));
                check_field("pad_out",      DATA_W'(want.pad_out), DATA_W'(pad_out));
                check_field("pad_oe",       DATA_W'(want.pad_oe), DATA_W'(pad_oe));
                check_field("pad_pullup",   DATA_W'(want.pad_pullup), DATA_W'(pad_pullup));
                check_field("pad_pulldown", DATA_W'(want.pad_pulldown),
                            DATA_W'(pad_pulldown));
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gpio_controller_edge_level_irq regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure: runs of free cycles and stalls, most stalls short
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n || !rsp_stall_on) begin
            rsp_stall  = 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if ($urandom_range(99) < 55) begin
            rsp_stall  = 1'b0;
            stall_hold = $urandom_range(20, 1) - 1;
        end else begin
            rsp_stall  = 1'b1;
            stall_hold = ($urandom_range(99) < 85) ? $urandom_range(3, 1) - 1
                                                   : $urandom_range(30, 8) - 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Gap before the next word: mostly none or short, now and then long
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (burst_mode || roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(25, 6);
    endfunction

    // Next pin levels: often hold (no edges), sometimes flip one pin, else all high, all low or random
    function automatic logic [PIN_W-1:0] next_levels();
        int unsigned roll;
        int unsigned pin;
        roll = $urandom_range(99);
        pin  = $urandom_range(PIN_W - 1);
        if (roll < 30)
            ;
        else if (roll < 55)
            cur_levels[pin] = ~cur_levels[pin];
        else if (roll < 62)
            cur_levels = '1;
        else if (roll < 69)
            cur_levels = '0;
        else
            cur_levels = PIN_W'($urandom);
        return cur_levels;
    endfunction

    // Present one request word at the falling edge and hold it until accepted.
    // Called and returns at a falling edge; valid stays high for a back-to-back word.
    task automatic send_word(input logic [MODE_W-1:0] md, input logic [SEL_W-1:0] sel,
                             input logic [DATA_W-1:0] wd, input logic [PIN_W-1:0] lv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  = 1'b1;
        mode       = md;
        reg_select = sel;
        write_data = wd;
        pin_levels = lv;
        do
            @(posedge clk);
        while (req_stall);
        compute_result_word(md, sel, wd, lv);
        @(negedge clk);
    endtask

    // Drop valid, wait for every predicted word, then let the pipeline settle
    task automatic drain_results();
        req_valid = 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_word();
        int unsigned      roll;
        logic [MODE_W-1:0] md;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] wd;
        roll = $urandom_range(99);
        if (roll < 35)
            md = MODE_TICK;
        else if (roll < 65)
            md = MODE_WRITE;
        else if (roll < 95)
            md = MODE_READ;
        else
            md = MODE_IDLE;
        // Mostly real registers, a share of the unused selects too
        sel = ($urandom_range(9) < 8) ? SEL_W'($urandom_range(SEL_LEVEL_STS))
                                      : SEL_W'($urandom_range(15));
        roll = $urandom_range(99);
        if (roll < 12)
            wd = '1;
        else if (roll < 20)
            wd = '0;
        else
            wd = $urandom;
        send_word(md, sel, wd, next_levels());
    endtask

    // A driver-like interrupt flow: arm enables, sample pins, read and clear status
    task automatic send_irq_sequence(output int sent);
        int ticks;
        ticks = $urandom_range(4, 1);
        send_word(MODE_WRITE, SEL_EDGE_EN, $urandom, PIN_W'($urandom));
        send_word(MODE_WRITE, SEL_LEVEL_EN, ($urandom_range(3) == 0) ? $urandom : 32'd0,
                  PIN_W'($urandom));
        repeat (ticks)
            send_word(MODE_TICK, SEL_W'($urandom_range(15)), $urandom, next_levels());
        send_word(MODE_READ, SEL_EDGE_STS, $urandom, PIN_W'($urandom));
        send_word(MODE_WRITE, SEL_EDGE_STS, ($urandom_range(1) == 0) ? '1 : $urandom,
                  PIN_W'($urandom));
        send_word(MODE_WRITE, SEL_LEVEL_STS, '1, PIN_W'($urandom));
        send_word(MODE_READ, SEL_LEVEL_STS, $urandom, PIN_W'($urandom));
        sent = ticks + 6;
    endtask

    // Set the pin count while idle, read it back, then run random traffic
    task automatic run_random_phase(input logic [CNT_W-1:0] pin_cfg, input int count);
        int sent;
        int chunk;
        drain_results();

        // APB write: setup cycle, then access cycle
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_PINS_IN_USE;
        pwdata  = {27'd0, pin_cfg};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_pin_cfg = pin_cfg;
        @(negedge clk);
        // APB read back of the same register
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", {27'd0, pin_cfg}, prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;

        sent = 0;
        while (sent < count) begin
            // Now and then switch to a stretch with no sender idling
            if ($urandom_range(49) == 0)
                burst_mode = ($urandom_range(3) == 0);
            if ($urandom_range(99) < 25) begin
                send_irq_sequence(chunk);
                sent += chunk;
            end else begin
                send_random_word();
                sent++;
            end
        end
        burst_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values, every register, first tick, edges, level refresh,
    // write-one-to-clear, read-only pin register, unused selects, idle mode
    task automatic test_directed_basics();
        send_word(MODE_READ,  SEL_OUT,       '0, '0);
        send_word(MODE_READ,  SEL_LEVEL_STS, '1, '1);
        send_word(MODE_TICK,  SEL_OUT,       '0, 16'h0000);
        send_word(MODE_TICK,  SEL_OUT,       '0, 16'hFFFF);
        send_word(MODE_TICK,  SEL_OUT,       '0, 16'hA5A5);
        send_word(MODE_WRITE, SEL_OUT,       '1, '0);
        send_word(MODE_WRITE, SEL_OE,        '1, '0);
        send_word(MODE_WRITE, SEL_PULLUP,    32'h5A5A_5A5A, '0);
        send_word(MODE_WRITE, SEL_PULLDOWN,  '1, '0);
        send_word(MODE_READ,  SEL_EDGE_STS,  '0, '0);
        send_word(MODE_WRITE, SEL_EDGE_EN,   '1, '0);
        send_word(MODE_WRITE, SEL_EDGE_STS,  '1, '0);
        send_word(MODE_WRITE, SEL_LEVEL_EN,  32'h0000_FFFF, '0);
        send_word(MODE_WRITE, SEL_LEVEL_STS, '1, '0);
        send_word(MODE_TICK,  SEL_OUT,       '0, 16'h0000);
        send_word(MODE_READ,  SEL_PINS,      '0, '0);
        send_word(MODE_WRITE, SEL_PINS,      '1, '1);
        send_word(MODE_WRITE, SEL_UNUSED_HI, '1, '0);
        send_word(MODE_READ,  SEL_UNUSED_LO, '0, '0);
        send_word(MODE_IDLE,  SEL_OUT,       '1, '1);
        send_word(MODE_READ,  SEL_LEVEL_EN,  '0, '0);
        send_word(MODE_WRITE, SEL_OUT,       '0, '0);
        send_word(MODE_WRITE, SEL_EDGE_EN,   '0, '0);
    endtask

    // Back-to-back words, hold the sender until every result is in, then more random words
    task automatic test_sender_drain();
        burst_mode = 1'b1;
        repeat (30) send_random_word();
        burst_mode = 1'b0;
        req_valid = 1'b0;
        while (predicted_words.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (30) send_random_word();
    endtask

    // Walk the pin count through extremes, out-of-range values and a random one
    task automatic test_pin_count_sweep();
        logic [CNT_W-1:0] settings[8];
        settings[0] = 5'd16;
        settings[1] = 5'd1;
        settings[2] = 5'd0;
        settings[3] = 5'd31;
        settings[4] = 5'd17;
        settings[5] = 5'd8;
        settings[6] = CNT_W'($urandom_range(15, 2));
        settings[7] = 5'd16;
        foreach (settings[i]) begin
            // Every other phase runs with the receiver never stalling
            rsp_stall_on = (i % 2 == 0);
            run_random_phase(settings[i], 150);
        end
        rsp_stall_on = 1'b1;
    endtask

    initial begin
        // Hold reset, then release it at a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_sender_drain();
        test_pin_count_sweep();

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && predicted_words.size() == 0)
            $display("gpio_controller_edge_level_irq regression: pass");
        else
            $display("gpio_controller_edge_level_irq regression: fail");
        $finish;
    end

endmodule
